// ===== hdl/assert_macros.svh =====
// Assertion helpers for the checker file bvm_chk.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while the active-low reset is low.
`define BVM_ASSERT_CLK(lbl, ck, rn, prop) \
  lbl: assert property (@(posedge ck) disable iff (!rn) prop) \
    else $error("bvm assertion failed");

// Same, on the usual clk / rst_n pair.
`define BVM_ASSERT(lbl, prop) \
  `BVM_ASSERT_CLK(lbl, clk, rst_n, prop)

`endif

// ===== hdl/bvm_pkg.sv =====
package bvm_pkg;

  localparam int MEM_BYTES = 4096;
  localparam int MEM_AW    = 12;
  localparam int STACK_DEPTH_DEF = 16;
  localparam int FONT_LEN  = 80;
  localparam logic [7:0]  TIMER_DIV_RST = 8'd8;
  localparam logic [11:0] START_PC = 12'h200;

  // request kinds
  localparam logic [1:0] REQ_LOAD = 2'd0;
  localparam logic [1:0] REQ_STEP = 2'd1;
  localparam logic [1:0] REQ_READ = 2'd2;

  // fault codes
  localparam logic [1:0] FLT_NONE    = 2'd0;
  localparam logic [1:0] FLT_BAD_OP  = 2'd1;
  localparam logic [1:0] FLT_KEYWAIT = 2'd2;

  // flag register index
  localparam logic [3:0] REG_VF = 4'hF;

  // opcode groups (high nibble)
  localparam logic [3:0] OP_SYS  = 4'h0;
  localparam logic [3:0] OP_JP   = 4'h1;
  localparam logic [3:0] OP_CALL = 4'h2;
  localparam logic [3:0] OP_SEI  = 4'h3;
  localparam logic [3:0] OP_SNEI = 4'h4;
  localparam logic [3:0] OP_SER  = 4'h5;
  localparam logic [3:0] OP_LDI  = 4'h6;
  localparam logic [3:0] OP_ADDI = 4'h7;
  localparam logic [3:0] OP_ALU  = 4'h8;
  localparam logic [3:0] OP_SNER = 4'h9;
  localparam logic [3:0] OP_LDIX = 4'hA;
  localparam logic [3:0] OP_JPV0 = 4'hB;
  localparam logic [3:0] OP_RND  = 4'hC;
  localparam logic [3:0] OP_DRW  = 4'hD;
  localparam logic [3:0] OP_KEY  = 4'hE;
  localparam logic [3:0] OP_MISC = 4'hF;

  // low byte sub-codes
  localparam logic [7:0] SUB_CLS  = 8'hE0;
  localparam logic [7:0] SUB_RET  = 8'hEE;
  localparam logic [7:0] SUB_SKP  = 8'h9E;
  localparam logic [7:0] SUB_SKNP = 8'hA1;
  localparam logic [7:0] SUB_GDT  = 8'h07;
  localparam logic [7:0] SUB_WKEY = 8'h0A;
  localparam logic [7:0] SUB_SDT  = 8'h15;
  localparam logic [7:0] SUB_SST  = 8'h18;
  localparam logic [7:0] SUB_ADDX = 8'h1E;
  localparam logic [7:0] SUB_FONT = 8'h29;
  localparam logic [7:0] SUB_BCD  = 8'h33;
  localparam logic [7:0] SUB_STR  = 8'h55;
  localparam logic [7:0] SUB_LDR  = 8'h65;

  // 8xyN function codes
  localparam logic [3:0] FN_MOV  = 4'h0;
  localparam logic [3:0] FN_OR   = 4'h1;
  localparam logic [3:0] FN_AND  = 4'h2;
  localparam logic [3:0] FN_XOR  = 4'h3;
  localparam logic [3:0] FN_ADD  = 4'h4;
  localparam logic [3:0] FN_SUB  = 4'h5;
  localparam logic [3:0] FN_SHR  = 4'h6;
  localparam logic [3:0] FN_SUBN = 4'h7;
  localparam logic [3:0] FN_SHL  = 4'hE;

  typedef enum logic [3:0] {
    ALU_PASS_B, ALU_OR, ALU_AND, ALU_XOR, ALU_ADD,
    ALU_SUB, ALU_SUBN, ALU_SHR, ALU_SHL
  } alu_op_t;

  typedef struct packed {
    alu_op_t    op;
    logic [7:0] a;
    logic [7:0] b;
  } alu_req_t;

  typedef struct packed {
    logic [7:0] res;
    logic       flag;
    logic       eq;
  } alu_res_t;

  localparam logic [7:0] FONT [FONT_LEN] = '{
    8'hf0, 8'h90, 8'h90, 8'h90, 8'hf0, 8'h20, 8'h60, 8'h20, 8'h20, 8'h70,
    8'hf0, 8'h10, 8'hf0, 8'h80, 8'hf0, 8'hf0, 8'h10, 8'hf0, 8'h10, 8'hf0,
    8'h90, 8'h90, 8'hf0, 8'h10, 8'h10, 8'hf0, 8'h80, 8'hf0, 8'h10, 8'hf0,
    8'hf0, 8'h80, 8'hf0, 8'h90, 8'hf0, 8'hf0, 8'h10, 8'h20, 8'h40, 8'h40,
    8'hf0, 8'h90, 8'hf0, 8'h90, 8'hf0, 8'hf0, 8'h90, 8'hf0, 8'h10, 8'hf0,
    8'hf0, 8'h90, 8'hf0, 8'h90, 8'h90, 8'he0, 8'h90, 8'he0, 8'h90, 8'he0,
    8'hf0, 8'h80, 8'h80, 8'h80, 8'hf0, 8'he0, 8'h90, 8'h90, 8'h90, 8'he0,
    8'hf0, 8'h80, 8'hf0, 8'h80, 8'hf0, 8'hf0, 8'h80, 8'hf0, 8'h80, 8'h80
  };

endpackage

// ===== hdl/bvm_alu.sv =====
module bvm_alu
  import bvm_pkg::*;
(
  input  alu_req_t req,
  output alu_res_t rsp
);

  logic [8:0] sum;
  assign sum = {1'b0, req.a} + {1'b0, req.b};

  always_comb begin
    rsp.eq   = (req.a == req.b);
    rsp.flag = 1'b0;
    rsp.res  = req.b;
    case (req.op)
      ALU_PASS_B: rsp.res = req.b;
      ALU_OR:     rsp.res = req.a | req.b;
      ALU_AND:    rsp.res = req.a & req.b;
      ALU_XOR:    rsp.res = req.a ^ req.b;
      ALU_ADD: begin
        rsp.res  = sum[7:0];
        rsp.flag = sum[8];
      end
      ALU_SUB: begin
        rsp.res  = req.a - req.b;
        rsp.flag = (req.a >= req.b);
      end
      ALU_SUBN: begin
        rsp.res  = req.b - req.a;
        rsp.flag = (req.b >= req.a);
      end
      ALU_SHR: begin
        rsp.res  = {1'b0, req.a[7:1]};
        rsp.flag = req.a[0];
      end
      ALU_SHL: begin
        rsp.res  = {req.a[6:0], 1'b0};
        rsp.flag = req.a[7];
      end
      default: rsp.res = req.b;
    endcase
  end

endmodule

// ===== hdl/bytecode_vm_execute_core.sv =====
// Bytecode interpreter core (CHIP-8 instruction set). One word in gives one word out.
// After reset the core writes the hex font and zeros into its 4 KiB RAM and takes no
// item meanwhile. A load word writes its byte and an unused request kind does nothing
// before the result word; a read word first reads its row in S_ROW. A step word runs
// S_FETCH0, S_FETCH1, S_FETCH2, S_RDY and S_EXEC, then as the opcode needs S_DRAW_A
// and S_DRAW_B per sprite row and S_WRVF for draws and flag-writing ALU ops, S_BCD per
// digit, or S_STORE_A/B or S_LOADM_A/B per register copied, and last S_TICK and S_RESP;
// the RAM and the register file each have one write port and one registered read port.
// The core takes one word at a time and is ready again once the result word has been
// taken. timer_divide may be written any time the core is idle; it is always ready.
module bytecode_vm_execute_core
  import bvm_pkg::*;
#(
  parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // lsb up: load_address[11:0], load_byte[19:12], key_states[35:20],
  // random_byte[43:36], row_select[48:44], zero pad
  input  logic [55:0] in_tdata,
  // req_type
  input  logic [1:0]  in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // lsb up: program_counter[11:0], sound_on[12], fault_code[14:13],
  // row_pixels[78:15], zero pad
  output logic [79:0] out_tdata,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_data
);

  localparam int SP_W = $clog2(STACK_DEPTH);
  localparam logic [SP_W-1:0] SP_LAST = SP_W'(STACK_DEPTH - 1);

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_FETCH0, S_FETCH1, S_FETCH2, S_RDY, S_EXEC, S_WRVF,
    S_DRAW_A, S_DRAW_B, S_BCD, S_STORE_A, S_STORE_B, S_LOADM_A, S_LOADM_B,
    S_ROW, S_TICK, S_RESP
  } state_t;

  state_t state_r;

  // architectural state
  logic [7:0]  gp_r [16];
  logic [11:0] stack_r [STACK_DEPTH];
  logic [SP_W-1:0] sp_r;
  logic [15:0] index_r;
  logic [11:0] pc_r;
  logic [7:0]  delay_r, sound_r, tick_r, div_r;
  logic [63:0] screen_r [32];
  logic [31:0] row_vld_r;
  logic [7:0]  mem_r [MEM_BYTES];

  // per-item working registers
  logic [MEM_AW-1:0] clr_addr_r;
  logic [7:0]  b0_r, b1_r, vx_r, vy_r, rnd_r, mem_q_r, rf_q_r;
  logic [15:0] keys_r;
  logic [3:0]  cnt_r;
  logic        flag_r;
  logic [1:0]  fault_r;
  logic [63:0] row_r, scr_q_r;

  // in_tdata fields
  logic [11:0] f_addr;
  logic [7:0]  f_byte, f_rnd;
  logic [15:0] f_keys;
  logic [4:0]  f_row;
  assign f_addr = in_tdata[11:0];
  assign f_byte = in_tdata[19:12];
  assign f_keys = in_tdata[35:20];
  assign f_rnd  = in_tdata[43:36];
  assign f_row  = in_tdata[48:44];

  logic in_acc;
  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  assign out_tvalid = (state_r == S_RESP);
  assign out_tdata  = {1'b0, row_r, fault_r, (sound_r != 8'd0), pc_r};

  // decoded opcode
  logic [3:0]  op, xi, yi, nn;
  logic [11:0] nnn, skip_pc;
  assign op  = b0_r[7:4];
  assign xi  = b0_r[3:0];
  assign yi  = b1_r[7:4];
  assign nn  = b1_r[3:0];
  assign nnn = {b0_r[3:0], b1_r};
  assign skip_pc = pc_r + 12'd2;   // pc_r already points past the opcode

  logic [11:0] idx_k;
  assign idx_k = index_r[11:0] + {8'd0, cnt_r};

  // shared ALU
  alu_req_t alu_req;
  alu_res_t alu_rsp;
  bvm_alu u_alu (.req(alu_req), .rsp(alu_rsp));

  always_comb begin
    alu_req.a  = (op == OP_RND) ? rnd_r : vx_r;
    alu_req.b  = rf_q_r;
    alu_req.op = ALU_PASS_B;
    case (op)
      OP_SEI, OP_SNEI, OP_LDI: alu_req.b = b1_r;
      OP_ADDI: begin
        alu_req.b  = b1_r;
        alu_req.op = ALU_ADD;
      end
      OP_RND: begin
        alu_req.b  = b1_r;
        alu_req.op = ALU_AND;
      end
      OP_ALU: begin
        case (nn)
          FN_OR:   alu_req.op = ALU_OR;
          FN_AND:  alu_req.op = ALU_AND;
          FN_XOR:  alu_req.op = ALU_XOR;
          FN_ADD:  alu_req.op = ALU_ADD;
          FN_SUB:  alu_req.op = ALU_SUB;
          FN_SHR:  alu_req.op = ALU_SHR;
          FN_SUBN: alu_req.op = ALU_SUBN;
          FN_SHL:  alu_req.op = ALU_SHL;
          default: alu_req.op = ALU_PASS_B;
        endcase
      end
      default: alu_req.op = ALU_PASS_B;
    endcase
  end

  logic alu_fn_ok, alu_fn_flag;
  assign alu_fn_ok = (nn == FN_MOV) || (nn == FN_OR) || (nn == FN_AND) ||
                     (nn == FN_XOR) || alu_fn_flag;
  assign alu_fn_flag = (nn == FN_ADD) || (nn == FN_SUB) || (nn == FN_SHR) ||
                       (nn == FN_SUBN) || (nn == FN_SHL);

  // BCD digits of Vx: compare for hundreds, reciprocal multiply for tens
  logic [1:0]  bcd_h;
  logic [6:0]  bcd_rem;
  logic [15:0] bcd_prod;
  logic [3:0]  bcd_t, bcd_o;
  logic [7:0]  bcd_digit;
  always_comb begin
    if (vx_r >= 8'd200) bcd_h = 2'd2;
    else if (vx_r >= 8'd100) bcd_h = 2'd1;
    else bcd_h = 2'd0;
    bcd_rem  = 7'(vx_r - 8'(bcd_h) * 8'd100);
    bcd_prod = 16'(bcd_rem) * 16'd205;
    bcd_t    = bcd_prod[14:11];
    bcd_o    = 4'(bcd_rem - 7'(bcd_t) * 7'd10);
    case (cnt_r[1:0])
      2'd0:    bcd_digit = {6'd0, bcd_h};
      2'd1:    bcd_digit = {4'd0, bcd_t};
      default: bcd_digit = {4'd0, bcd_o};
    endcase
  end

  // sprite row mask, wrapped around the 64 columns
  logic [127:0] spr_rot;
  logic [63:0]  spr_mask;
  assign spr_rot  = {mem_q_r, 56'd0, mem_q_r, 56'd0} >> vx_r[5:0];
  assign spr_mask = spr_rot[63:0];

  logic [4:0] draw_row;
  assign draw_row = 5'(vy_r + {4'd0, cnt_r});

  // RAM port control
  logic              mem_we;
  logic [MEM_AW-1:0] mem_waddr, mem_raddr;
  logic [7:0]        mem_wdata;
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = idx_k;
    mem_wdata = rf_q_r;
    mem_raddr = idx_k;
    case (state_r)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_addr_r;
        mem_wdata = (clr_addr_r < MEM_AW'(FONT_LEN)) ? FONT[clr_addr_r[6:0]] : 8'd0;
      end
      S_IDLE: begin
        mem_we    = in_acc && (in_tuser == REQ_LOAD);
        mem_waddr = f_addr;
        mem_wdata = f_byte;
      end
      S_FETCH0: mem_raddr = pc_r;
      S_FETCH1: mem_raddr = pc_r + 12'd1;
      S_BCD: begin
        mem_we    = 1'b1;
        mem_wdata = bcd_digit;
      end
      S_STORE_B: mem_we = 1'b1;
      default: mem_we = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem_r[mem_waddr] <= mem_wdata;
    end
    mem_q_r <= mem_r[mem_raddr];
  end

  // register file port control
  logic       rf_we;
  logic [3:0] rf_waddr, rf_raddr;
  logic [7:0] rf_wdata;
  always_comb begin
    rf_raddr = cnt_r;
    case (state_r)
      S_FETCH2: rf_raddr = xi;
      S_RDY:    rf_raddr = (op == OP_JPV0) ? 4'd0 : yi;
      default:  rf_raddr = cnt_r;
    endcase
  end

  always_comb begin
    rf_we    = 1'b0;
    rf_waddr = xi;
    rf_wdata = alu_rsp.res;
    case (state_r)
      S_EXEC: begin
        case (op)
          OP_LDI, OP_ADDI, OP_RND: rf_we = 1'b1;
          OP_ALU: rf_we = alu_fn_ok;
          OP_MISC: begin
            rf_we    = (b1_r == SUB_GDT);
            rf_wdata = delay_r;
          end
          default: rf_we = 1'b0;
        endcase
      end
      S_WRVF: begin
        rf_we    = 1'b1;
        rf_waddr = REG_VF;
        rf_wdata = {7'd0, flag_r};
      end
      S_LOADM_B: begin
        rf_we    = 1'b1;
        rf_waddr = cnt_r;
        rf_wdata = mem_q_r;
      end
      default: rf_we = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 16; i++) gp_r[i] <= 8'd0;
    end else if (rf_we) begin
      gp_r[rf_waddr] <= rf_wdata;
    end
  end

  always_ff @(posedge clk) begin
    rf_q_r <= gp_r[rf_raddr];
  end

  // framebuffer rows, one read port; an invalid row reads as blank
  logic [4:0] scr_raddr;
  logic       scr_we;
  assign scr_raddr = (state_r == S_IDLE) ? f_row : draw_row;
  assign scr_we    = (state_r == S_DRAW_B);

  always_ff @(posedge clk) begin
    if (scr_we) begin
      screen_r[draw_row] <= scr_q_r ^ spr_mask;
    end
    scr_q_r <= row_vld_r[scr_raddr] ? screen_r[scr_raddr] : 64'd0;
  end

  // sequencer
  logic [7:0] tick_inc;
  assign tick_inc = tick_r + 8'd1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_CLEAR;
      clr_addr_r <= '0;
      sp_r       <= '0;
      index_r    <= 16'd0;
      pc_r       <= START_PC;
      delay_r    <= 8'd0;
      sound_r    <= 8'd0;
      tick_r     <= 8'd0;
      div_r      <= TIMER_DIV_RST;
      row_vld_r  <= 32'd0;
      fault_r    <= FLT_NONE;
      row_r      <= 64'd0;
      cnt_r      <= 4'd0;
      flag_r     <= 1'b0;
      for (int i = 0; i < STACK_DEPTH; i++) stack_r[i] <= 12'd0;
    end else begin
      if (cfg_valid && cfg_ready) div_r <= cfg_data;
      case (state_r)
        S_CLEAR: begin
          clr_addr_r <= clr_addr_r + 1'b1;
          if (clr_addr_r == MEM_AW'(MEM_BYTES - 1)) state_r <= S_IDLE;
        end
        S_IDLE: begin
          if (in_acc) begin
            fault_r <= FLT_NONE;
            row_r   <= 64'd0;
            keys_r  <= f_keys;
            rnd_r   <= f_rnd;
            case (in_tuser)
              REQ_STEP: state_r <= S_FETCH0;
              REQ_READ: state_r <= S_ROW;
              default:  state_r <= S_RESP;
            endcase
          end
        end
        S_ROW: begin
          row_r   <= scr_q_r;
          state_r <= S_RESP;
        end
        S_FETCH0: state_r <= S_FETCH1;
        S_FETCH1: begin
          b0_r    <= mem_q_r;
          state_r <= S_FETCH2;
        end
        S_FETCH2: begin
          b1_r    <= mem_q_r;
          pc_r    <= pc_r + 12'd2;
          state_r <= S_RDY;
        end
        S_RDY: begin
          vx_r    <= rf_q_r;
          state_r <= S_EXEC;
        end
        S_EXEC: begin
          vy_r    <= rf_q_r;
          cnt_r   <= 4'd0;
          state_r <= S_TICK;
          case (op)
            OP_SYS: begin
              if (b1_r == SUB_CLS) begin
                row_vld_r <= 32'd0;
              end else if (b1_r == SUB_RET) begin
                sp_r <= (sp_r == '0) ? SP_LAST : sp_r - 1'b1;
                pc_r <= stack_r[(sp_r == '0) ? SP_LAST : sp_r - 1'b1];
              end else begin
                fault_r <= FLT_BAD_OP;
              end
            end
            OP_JP: pc_r <= nnn;
            OP_CALL: begin
              stack_r[sp_r] <= pc_r;
              sp_r <= (sp_r == SP_LAST) ? '0 : sp_r + 1'b1;
              pc_r <= nnn;
            end
            OP_SEI, OP_SER:  if (alu_rsp.eq) pc_r <= skip_pc;
            OP_SNEI, OP_SNER: if (!alu_rsp.eq) pc_r <= skip_pc;
            OP_ALU: begin
              flag_r <= alu_rsp.flag;
              if (!alu_fn_ok) fault_r <= FLT_BAD_OP;
              else if (alu_fn_flag) state_r <= S_WRVF;
            end
            OP_LDIX: index_r <= {4'd0, nnn};
            OP_JPV0: pc_r <= nnn + {4'd0, rf_q_r};
            OP_DRW: begin
              flag_r  <= 1'b0;
              state_r <= (nn == 4'd0) ? S_WRVF : S_DRAW_A;
            end
            OP_KEY: begin
              if (b1_r == SUB_SKP) begin
                if (keys_r[vx_r[3:0]]) pc_r <= skip_pc;
              end else if (b1_r == SUB_SKNP) begin
                if (!keys_r[vx_r[3:0]]) pc_r <= skip_pc;
              end else begin
                fault_r <= FLT_BAD_OP;
              end
            end
            OP_LDI, OP_ADDI, OP_RND: state_r <= S_TICK;
            default: begin
              case (b1_r)
                SUB_GDT:  state_r <= S_TICK;
                SUB_WKEY: fault_r <= FLT_KEYWAIT;
                SUB_SDT:  delay_r <= vx_r;
                SUB_SST:  sound_r <= vx_r;
                SUB_ADDX: index_r <= index_r + {8'd0, vx_r};
                SUB_FONT: index_r <= {6'd0, vx_r, 2'b00} + {8'd0, vx_r};
                SUB_BCD:  state_r <= S_BCD;
                SUB_STR:  state_r <= S_STORE_A;
                SUB_LDR:  state_r <= S_LOADM_A;
                default:  fault_r <= FLT_BAD_OP;
              endcase
            end
          endcase
        end
        S_WRVF: state_r <= S_TICK;
        S_DRAW_A: state_r <= S_DRAW_B;
        S_DRAW_B: begin
          row_vld_r[draw_row] <= 1'b1;
          if ((scr_q_r & spr_mask) != 64'd0) flag_r <= 1'b1;
          cnt_r <= cnt_r + 4'd1;
          state_r <= (cnt_r == nn - 4'd1) ? S_WRVF : S_DRAW_A;
        end
        S_BCD: begin
          cnt_r <= cnt_r + 4'd1;
          if (cnt_r == 4'd2) state_r <= S_TICK;
        end
        S_STORE_A: state_r <= S_STORE_B;
        S_STORE_B: begin
          cnt_r   <= cnt_r + 4'd1;
          state_r <= (cnt_r == xi) ? S_TICK : S_STORE_A;
        end
        S_LOADM_A: state_r <= S_LOADM_B;
        S_LOADM_B: begin
          cnt_r   <= cnt_r + 4'd1;
          state_r <= (cnt_r == xi) ? S_TICK : S_LOADM_A;
        end
        S_TICK: begin
          if (tick_inc >= div_r) begin
            tick_r <= 8'd0;
            if (delay_r != 8'd0) delay_r <= delay_r - 8'd1;
            if (sound_r != 8'd0) sound_r <= sound_r - 8'd1;
          end else begin
            tick_r <= tick_inc;
          end
          state_r <= S_RESP;
        end
        S_RESP: if (out_tready) state_r <= S_IDLE;
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== hdl/bvm_chk.sv =====
`include "assert_macros.svh"

module bvm_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [79:0] out_tdata
);

  // a pending result is never dropped
  `BVM_ASSERT(a_out_hold, out_tvalid && !out_tready |=> out_tvalid)
  // one word in flight: no intake while a result waits
  `BVM_ASSERT(a_one_inflight, out_tvalid |-> !in_tready)
  // after a word is taken the core is busy on it
  `BVM_ASSERT(a_busy_after_acc, in_tvalid && in_tready |=> !in_tready)
  // fault field only carries defined codes
  `BVM_ASSERT(a_fault_code, out_tvalid |-> out_tdata[14:13] != 2'd3)

endmodule

bind bytecode_vm_execute_core bvm_chk u_bvm_chk (.*);

// ===== test/bvm_exec_checker.sv =====
`timescale 1ns / 1ps

// Watches the word channels of the interpreter core, keeps its own model of
// the machine state, and checks every result word against the oldest
// predicted one.
module bvm_exec_checker
  import bvm_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [55:0] in_tdata,
  input  logic [1:0]  in_tuser,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [79:0] out_tdata,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [7:0]  cfg_data,
  output int          fails,
  output int          pending
);

  // msb first, so pc lands in the low bits as on out_tdata
  typedef struct packed {
    logic [63:0] row;
    logic [1:0]  flt;
    logic        snd;
    logic [11:0] pc;
  } vm_res_t;

  logic [7:0]  ram [MEM_BYTES];
  logic [7:0]  vreg [16];
  logic [15:0] ireg;
  logic [11:0] pc;
  logic [11:0] rstack [STACK_DEPTH_DEF];
  logic [3:0]  sp;
  logic [7:0]  dt, st, ticks, divide;
  logic [63:0] scr [32];
  vm_res_t     want_q [$];

  task automatic clear_state();
    for (int a = 0; a < MEM_BYTES; a++) ram[a] = (a < FONT_LEN) ? FONT[a] : 8'h00;
    for (int k = 0; k < 16; k++) begin
      vreg[k] = 8'h00;
      rstack[k] = 12'h000;
    end
    for (int r = 0; r < 32; r++) scr[r] = 64'd0;
    ireg = 16'h0000;
    pc = START_PC;
    sp = 4'd0;
    dt = 8'h00;
    st = 8'h00;
    ticks = 8'h00;
    divide = TIMER_DIV_RST;
  endtask

  // XOR draw with wrap on both axes; returns the collision flag
  function automatic logic draw(input logic [7:0] x0, input logic [7:0] y0,
                                input logic [3:0] rows);
    logic       hit;
    logic [7:0] bits;
    logic [4:0] yy;
    logic [5:0] col;
    hit = 1'b0;
    for (int r = 0; r < rows; r++) begin
      bits = ram[12'(ireg + r)];
      yy = 5'(y0 + r);
      for (int c = 0; c < 8; c++) begin
        if (bits[7 - c]) begin
          col = 6'(x0 + c);
          if (scr[yy][63 - col]) hit = 1'b1;
          scr[yy][63 - col] = ~scr[yy][63 - col];
        end
      end
    end
    return hit;
  endfunction

  function automatic logic [1:0] exec_op(input logic [15:0] keys, input logic [7:0] rnd);
    logic [7:0]  b0, b1;
    logic [3:0]  x, y, n;
    logic [11:0] nnn, skip;
    logic [1:0]  flt;
    logic [8:0]  sum;
    logic        f;
    b0 = ram[pc];
    b1 = ram[12'(pc + 1)];
    x = b0[3:0];
    y = b1[7:4];
    n = b1[3:0];
    nnn = {x, b1};
    skip = 12'(pc + 4);
    flt = FLT_NONE;
    pc = 12'(pc + 2);
    case (b0[7:4])
      OP_SYS: begin
        if (b1 == SUB_CLS) begin
          for (int r = 0; r < 32; r++) scr[r] = 64'd0;
        end else if (b1 == SUB_RET) begin
          sp = sp - 4'd1;
          pc = rstack[sp];
        end else flt = FLT_BAD_OP;
      end
      OP_JP: pc = nnn;
      OP_CALL: begin
        rstack[sp] = pc;
        sp = sp + 4'd1;
        pc = nnn;
      end
      OP_SEI:  if (vreg[x] == b1) pc = skip;
      OP_SNEI: if (vreg[x] != b1) pc = skip;
      OP_SER:  if (vreg[x] == vreg[y]) pc = skip;
      OP_LDI:  vreg[x] = b1;
      OP_ADDI: vreg[x] = vreg[x] + b1;
      OP_ALU: begin
        case (n)
          FN_MOV: vreg[x] = vreg[y];
          FN_OR:  vreg[x] = vreg[x] | vreg[y];
          FN_AND: vreg[x] = vreg[x] & vreg[y];
          FN_XOR: vreg[x] = vreg[x] ^ vreg[y];
          FN_ADD: begin
            sum = vreg[x] + vreg[y];
            vreg[x] = sum[7:0];
            vreg[REG_VF] = {7'd0, sum[8]};
          end
          FN_SUB: begin
            f = vreg[x] >= vreg[y];
            vreg[x] = vreg[x] - vreg[y];
            vreg[REG_VF] = {7'd0, f};
          end
          FN_SHR: begin
            f = vreg[x][0];
            vreg[x] = vreg[x] >> 1;
            vreg[REG_VF] = {7'd0, f};
          end
          FN_SUBN: begin
            f = vreg[y] >= vreg[x];
            vreg[x] = vreg[y] - vreg[x];
            vreg[REG_VF] = {7'd0, f};
          end
          FN_SHL: begin
            f = vreg[x][7];
            vreg[x] = vreg[x] << 1;
            vreg[REG_VF] = {7'd0, f};
          end
          default: flt = FLT_BAD_OP;
        endcase
      end
      OP_SNER: if (vreg[x] != vreg[y]) pc = skip;
      OP_LDIX: ireg = {4'h0, nnn};
      OP_JPV0: pc = 12'(nnn + vreg[0]);
      OP_RND:  vreg[x] = rnd & b1;
      OP_DRW: begin
        f = draw(vreg[x], vreg[y], n);
        vreg[REG_VF] = {7'd0, f};
      end
      OP_KEY: begin
        f = keys[vreg[x][3:0]];
        if (b1 == SUB_SKP) begin
          if (f) pc = skip;
        end else if (b1 == SUB_SKNP) begin
          if (!f) pc = skip;
        end else flt = FLT_BAD_OP;
      end
      default: begin
        case (b1)
          SUB_GDT:  vreg[x] = dt;
          SUB_WKEY: flt = FLT_KEYWAIT;
          SUB_SDT:  dt = vreg[x];
          SUB_SST:  st = vreg[x];
          SUB_ADDX: ireg = ireg + vreg[x];
          SUB_FONT: ireg = vreg[x] * 16'd5;
          SUB_BCD: begin
            ram[12'(ireg)]     = vreg[x] / 8'd100;
            ram[12'(ireg + 1)] = (vreg[x] % 8'd100) / 8'd10;
            ram[12'(ireg + 2)] = vreg[x] % 8'd10;
          end
          SUB_STR: for (int k = 0; k <= x; k++) ram[12'(ireg + k)] = vreg[k];
          SUB_LDR: for (int k = 0; k <= x; k++) vreg[k] = ram[12'(ireg + k)];
          default: flt = FLT_BAD_OP;
        endcase
      end
    endcase
    return flt;
  endfunction

  function automatic vm_res_t run_word(input logic [1:0] kind, input logic [55:0] d);
    vm_res_t res;
    res = '0;
    case (kind)
      REQ_LOAD: ram[d[11:0]] = d[19:12];
      REQ_STEP: begin
        res.flt = exec_op(d[35:20], d[43:36]);
        ticks = ticks + 8'd1;
        if (ticks >= divide) begin
          ticks = 8'd0;
          if (dt != 0) dt = dt - 8'd1;
          if (st != 0) st = st - 8'd1;
        end
      end
      REQ_READ: res.row = scr[d[48:44]];
      default: ;
    endcase
    res.pc = pc;
    res.snd = st != 0;
    return res;
  endfunction

  initial begin
    fails = 0;
    pending = 0;
    clear_state();
  end

  always @(posedge clk) begin
    vm_res_t w, got;
    if (!rst_n) begin
      clear_state();
      want_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) divide = cfg_data;
      if (out_tvalid && out_tready) begin
        got = out_tdata[78:0];
        if (want_q.size() == 0) begin
          $display("%0t: unexpected result word %h", $time, got);
          fails++;
        end else begin
          w = want_q.pop_front();
          if (got.pc !== w.pc) begin
            $display("%0t: pc exp %h got %h", $time, w.pc, got.pc);
            fails++;
          end
          if (got.snd !== w.snd) begin
            $display("%0t: sound exp %b got %b", $time, w.snd, got.snd);
            fails++;
          end
          if (got.flt !== w.flt) begin
            $display("%0t: fault exp %0d got %0d", $time, w.flt, got.flt);
            fails++;
          end
          if (got.row !== w.row) begin
            $display("%0t: row exp %h got %h", $time, w.row, got.row);
            fails++;
          end
        end
      end
      if (in_tvalid && in_tready) want_q.push_back(run_word(in_tuser, in_tdata));
    end
    pending = want_q.size();
  end

endmodule

// ===== test/tb_bytecode_vm_execute_core.sv =====
`timescale 1ns / 1ps

// Stimulus and verdict. Checking lives in bvm_exec_checker.
module tb_bytecode_vm_execute_core;
  import bvm_pkg::*;

  localparam logic [1:0] REQ_SPARE = 2'd3;   // unused request kind
  localparam int ITEM_TARGET = 1050;
  localparam int IDLE_LIMIT  = 20000;        // covers the RAM clear after reset

  logic        clk;
  logic        rst_n;
  logic        in_tvalid, in_tready;
  logic [55:0] in_tdata;
  logic [1:0]  in_tuser;
  logic        out_tvalid, out_tready;
  logic [79:0] out_tdata;
  logic        cfg_valid, cfg_ready;
  logic [7:0]  cfg_data;

  int          fails, pending;
  int          items;
  int          idle_cycles;
  bit          hold_req;   // asks the receiver for one long hold-off
  bit          burst;      // no idling on either side
  logic [11:0] last_pc;

  bytecode_vm_execute_core dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  bvm_exec_checker chk (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .fails(fails), .pending(pending)
  );

  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  // mostly short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (burst || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(5, 30);
  endfunction

  // PC of the last result word; the sender starts a program block there
  always @(posedge clk) begin
    if (!rst_n) last_pc <= START_PC;
    else if (out_tvalid && out_tready) last_pc <= out_tdata[11:0];
  end

  // watchdog: cycles with no handshake on any channel
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // result side: random backpressure, plus one long hold-off on request
  initial begin
    int n;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_tready <= 1'b0;
        repeat (300) @(negedge clk);
        hold_req = 1'b0;
      end else begin
        n = pick_gap();
        if (n == 0) out_tready <= 1'b1;
        else begin
          out_tready <= 1'b0;
          repeat (n - 1) @(negedge clk);
        end
      end
    end
  end

  // valid drops right after the handshake so a word is never taken twice
  task automatic send_word(input logic [1:0] kind, input logic [55:0] d);
    int g;
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= d;
    do @(posedge clk); while (!in_tready);
    items++;
    @(negedge clk);
    in_tvalid <= 1'b0;
    g = pick_gap();
    if (g > 1) repeat (g - 1) @(negedge clk);
  endtask

  // data layout lsb up: addr, byte, keys, random, row, pad
  task automatic send_load(input logic [11:0] a, input logic [7:0] b);
    send_word(REQ_LOAD, {7'd0, 5'($urandom), 8'($urandom), 16'($urandom), b, a});
  endtask

  task automatic send_step(input logic [15:0] keys, input logic [7:0] rnd);
    send_word(REQ_STEP, {7'd0, 5'($urandom), rnd, keys, 8'($urandom), 12'($urandom)});
  endtask

  task automatic send_read(input logic [4:0] r);
    send_word(REQ_READ, {7'd0, r, 8'($urandom), 16'($urandom), 8'($urandom), 12'($urandom)});
  endtask

  // store an opcode big-endian at a, wrapping at 12 bits
  task automatic put_op(input logic [11:0] a, input logic [15:0] op);
    send_load(a, op[15:8]);
    send_load(a + 12'd1, op[7:0]);
  endtask

  // idle: nothing expected, then room for the longest step (block copy of 16)
  task automatic settle();
    while (pending != 0) @(negedge clk);
    repeat (50) @(negedge clk);
  endtask

  task automatic write_divide(input logic [7:0] v);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [15:0] make_op(input logic [11:0] base);
    logic [3:0]  g, x, y;
    logic [7:0]  kk;
    logic [11:0] tgt;
    int          r;
    logic [7:0]  misc [9] = '{SUB_GDT, SUB_WKEY, SUB_SDT, SUB_SST, SUB_ADDX,
                              SUB_FONT, SUB_BCD, SUB_STR, SUB_LDR};
    logic [3:0]  fns [9] = '{FN_MOV, FN_OR, FN_AND, FN_XOR, FN_ADD,
                             FN_SUB, FN_SHR, FN_SUBN, FN_SHL};
    g  = 4'($urandom);
    x  = 4'($urandom);
    y  = 4'($urandom);
    kk = 8'($urandom);
    r  = $urandom_range(0, 9);
    // branch targets mostly land near the running block
    tgt = (r < 6) ? base + 12'($urandom_range(0, 63)) : 12'($urandom);
    case (g)
      OP_SYS: begin
        if (r < 4) return {OP_SYS, 4'h0, SUB_CLS};
        if (r < 8) return {OP_SYS, 4'h0, SUB_RET};
        return {OP_SYS, x, kk};
      end
      OP_JP, OP_CALL, OP_JPV0, OP_LDIX: return {g, tgt};
      OP_ALU: return {OP_ALU, x, y, (r < 9) ? fns[$urandom_range(0, 8)] : 4'($urandom)};
      OP_DRW: return {OP_DRW, x, y, 4'($urandom)};
      OP_KEY: begin
        if (r < 5) return {OP_KEY, x, SUB_SKP};
        if (r < 9) return {OP_KEY, x, SUB_SKNP};
        return {OP_KEY, x, kk};
      end
      OP_MISC: return {OP_MISC, x, (r < 9) ? misc[$urandom_range(0, 8)] : kk};
      default: return {g, x, kk};
    endcase
  endfunction

  function automatic logic [15:0] pick_keys();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 16'h0000;
    if (r == 1) return 16'hFFFF;
    return 16'($urandom);
  endfunction

  initial begin
    static logic [15:0] prog [8] = '{
      16'h63FF,   // V3 = FF
      16'h8F34,   // VF + V3 with x = F: flag wins
      16'h643F,   // V4 = 3F
      16'hD445,   // glyph 0 at (63,63): wraps both edges
      16'hF433,   // BCD of 63
      16'h0000,   // invalid opcode
      16'hF00A,   // key wait
      16'hD440    // zero height draw
    };
    logic [11:0] base;
    static logic [7:0] divs [5] = '{8'd1, 8'd255, 8'd3, 8'd8, 8'd2};
    int          phase, k, r;

    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = REQ_LOAD;
    cfg_valid = 1'b0;
    cfg_data = '0;
    items = 0;
    idle_cycles = 0;
    hold_req = 1'b0;
    burst = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: a short program at the reset PC
    for (int i = 0; i < 8; i++) put_op(START_PC + 12'(2 * i), prog[i]);
    for (int i = 0; i < 8; i++) send_step(16'hFFFF, 8'hFF);
    send_read(5'd31);
    settle();

    phase = 0;
    while (items < ITEM_TARGET) begin
      if (items >= (phase + 1) * 200 && phase < 5) begin
        settle();
        write_divide(divs[phase]);
        phase++;
        burst = ($urandom_range(0, 3) == 0);
      end
      settle();
      base = last_pc;
      k = $urandom_range(1, 8);
      if (items > 500 && items < 530) hold_req = 1'b1;
      for (int i = 0; i < k; i++) put_op(base + 12'(2 * i), make_op(base));
      for (int i = 0; i < k; i++) send_step(pick_keys(), 8'($urandom));
      // reads and noise
      r = $urandom_range(0, 9);
      if (r < 4) send_read(5'($urandom));
      else if (r == 4) send_word(REQ_SPARE, 56'($urandom) ^ {24'($urandom), 32'd0});
      else if (r == 5) send_load(12'($urandom), 8'($urandom));
      else if (r == 6) send_step(pick_keys(), 8'($urandom));
    end

    settle();
    if (fails == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

endmodule
